[src/hpc_pkg.sv]
package hpc_pkg;

  localparam int COORD_WIDTH_DEF  = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // angle unit: fit, products, cross/dot, reduce, CORDIC stages, clamp
  localparam int ANG_FIXED_STAGES = 5;
  // input, vector set-up, ratio prep, two divider set-up stages, 32 quotient bits, output
  localparam int PIPE_FIXED_STAGES = 38;

  localparam logic [30:0]        HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [31:0] ONE_Q16     = 32'sd65536;
  localparam logic signed [31:0] RATIO_MAX_RESET = 32'sd131072;

  typedef enum logic [1:0] {
    STATUS_COMPUTED  = 2'd0,
    STATUS_COLLINEAR = 2'd1,
    STATUS_DEFAULT   = 2'd2
  } status_e;

  typedef enum logic {
    REG_RATIO_MIN = 1'b0,
    REG_RATIO_MAX = 1'b1
  } reg_e;

  typedef struct packed {
    status_e status;
    logic    neg;
  } div_tag_t;

  function automatic int pipe_latency(input int steps);
    return PIPE_FIXED_STAGES + ANG_FIXED_STAGES + steps;
  endfunction

  // atan(2^-i) in Q2.30, rounded to nearest
  function automatic logic [30:0] atan_q30(input int i);
    logic [30:0] r;
    case (i)
      0:       r = 31'd843314857;
      1:       r = 31'd497837829;
      2:       r = 31'd263043837;
      3:       r = 31'd133525159;
      4:       r = 31'd67021687;
      5:       r = 31'd33543516;
      6:       r = 31'd16775851;
      7:       r = 31'd8388437;
      8:       r = 31'd4194283;
      9:       r = 31'd2097149;
      10:      r = 31'd1048576;
      11:      r = 31'd524288;
      12:      r = 31'd262144;
      13:      r = 31'd131072;
      14:      r = 31'd65536;
      15:      r = 31'd32768;
      16:      r = 31'd16384;
      17:      r = 31'd8192;
      18:      r = 31'd4096;
      19:      r = 31'd2048;
      20:      r = 31'd1024;
      21:      r = 31'd512;
      22:      r = 31'd256;
      23:      r = 31'd128;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

endpackage

[src/helix_ip_hit_pair_check_core.sv]
// Hit pair helix compatibility check.
// Issue a pair of hits (parent and child x, y, z) with start; a transaction
// is taken at every rising edge with start high and busy low. busy stays
// low: the pipeline takes a new transaction in every cycle.
// Each result shows on compatible_o, ratio_value_o and ratio_status_o for
// exactly one cycle, flagged by done_o, in transaction order. The receiver
// cannot stall the block, so results are never held back.
// From accept to done_o a transaction passes the input and vector set-up
// registers, the two angle units with their CORDIC stages, ratio prep,
// divider set-up, the 32 one-bit stages of the ratio divider and the
// output register. Throughput: one transaction per cycle.
// The APB port holds ratio_min (0x0) and ratio_max (0x4), signed Q16.16;
// write them only while no transaction is in flight. Reset clears all
// valid bits and loads ratio_min = 0.0 and ratio_max = 2.0.
module helix_ip_hit_pair_check_core #(
  parameter int COORD_WIDTH  = hpc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] parent_x_i,
  input  logic signed [COORD_WIDTH-1:0] parent_y_i,
  input  logic signed [COORD_WIDTH-1:0] parent_z_i,
  input  logic signed [COORD_WIDTH-1:0] child_x_i,
  input  logic signed [COORD_WIDTH-1:0] child_y_i,
  input  logic signed [COORD_WIDTH-1:0] child_z_i,
  output logic                          done_o,
  output logic                          compatible_o,
  output logic signed [31:0]            ratio_value_o,
  output logic [1:0]                    ratio_status_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int CW      = COORD_WIDTH;
  localparam int ANG_LAT = hpc_pkg::ANG_FIXED_STAGES + CORDIC_STEPS;

  typedef struct packed {
    logic                 col;
    logic signed [CW-1:0] az;
    logic signed [CW-1:0] bz;
  } side_t;

  // ---------------- configuration registers ----------------
  logic signed [31:0] ratio_min_q, ratio_max_q;
  logic               cfg_wr;
  hpc_pkg::reg_e      cfg_sel;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign cfg_sel = hpc_pkg::reg_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_min_q <= 32'sd0;
      ratio_max_q <= hpc_pkg::RATIO_MAX_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        hpc_pkg::REG_RATIO_MIN: ratio_min_q <= $signed(pwdata);
        hpc_pkg::REG_RATIO_MAX: ratio_max_q <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      hpc_pkg::REG_RATIO_MIN: prdata = ratio_min_q;
      hpc_pkg::REG_RATIO_MAX: prdata = ratio_max_q;
      default:                prdata = 32'd0;
    endcase
  end

  // ---------------- input stage ----------------
  logic                 v0_q;
  logic signed [CW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= parent_x_i;
    ay_q <= parent_y_i;
    az_q <= parent_z_i;
    bx_q <= child_x_i;
    by_q <= child_y_i;
    bz_q <= child_z_i;
  end

  // ---------------- vector set-up ----------------
  // angle at the parent: towards origin and towards child
  // angle at the origin: towards parent and towards child
  logic                   v1_q;
  logic signed [CW:0]     apx_q, apy_q, aqx_q, aqy_q;
  logic signed [CW:0]     bpx_q, bpy_q, bqx_q, bqy_q;
  logic signed [2*CW-1:0] pab_q, pba_q;
  logic signed [CW-1:0]   az1_q, bz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    apx_q <= -(CW+1)'(ax_q);
    apy_q <= -(CW+1)'(ay_q);
    aqx_q <= (CW+1)'(bx_q) - (CW+1)'(ax_q);
    aqy_q <= (CW+1)'(by_q) - (CW+1)'(ay_q);
    bpx_q <= (CW+1)'(ax_q);
    bpy_q <= (CW+1)'(ay_q);
    bqx_q <= (CW+1)'(bx_q);
    bqy_q <= (CW+1)'(by_q);
    pab_q <= ax_q * by_q;
    pba_q <= ay_q * bx_q;
    az1_q <= az_q;
    bz1_q <= bz_q;
  end

  // ---------------- angle units ----------------
  logic [30:0] a1, a2;

  hpc_angle #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_angle_par (
    .clk_i  (clk_i),
    .px_i   (apx_q),
    .py_i   (apy_q),
    .qx_i   (aqx_q),
    .qy_i   (aqy_q),
    .angle_o(a1)
  );

  hpc_angle #(
    .COORD_WIDTH (COORD_WIDTH),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_angle_org (
    .clk_i  (clk_i),
    .px_i   (bpx_q),
    .py_i   (bpy_q),
    .qx_i   (bqx_q),
    .qy_i   (bqy_q),
    .angle_o(a2)
  );

  // delay line that keeps z values and the collinear flag beside the angles
  side_t side_q [0:ANG_LAT-1];
  logic  sv_q   [0:ANG_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ANG_LAT; i++) sv_q[i] <= 1'b0;
    end else begin
      sv_q[0] <= v1_q;
      for (int i = 1; i < ANG_LAT; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{col: (pab_q == pba_q), az: az1_q, bz: bz1_q};
    for (int i = 1; i < ANG_LAT; i++) side_q[i] <= side_q[i-1];
  end

  // ---------------- ratio preparation ----------------
  side_t              sd;
  logic signed [33:0] dz;
  logic [33:0]        dmag, zmag;
  hpc_pkg::div_tag_t  prep_tag;

  assign sd = side_q[ANG_LAT-1];

  always_comb begin
    dz   = 34'(sd.az) - 34'(sd.bz);
    dmag = dz[33] ? 34'(-dz) : 34'(dz);
    zmag = sd.bz[CW-1] ? 34'(-34'(sd.bz)) : 34'(34'(sd.bz));
    // scale numerator and denominator together below 2^31
    for (int k = 0; k < 2; k++) begin
      if ((dmag | zmag) >= 34'h080000000) begin
        dmag = dmag >> 1;
        zmag = zmag >> 1;
      end
    end
    if (sd.col) begin
      prep_tag.status = hpc_pkg::STATUS_COLLINEAR;
    end else if (a2 == 31'd0 || sd.bz == '0) begin
      prep_tag.status = hpc_pkg::STATUS_DEFAULT;
    end else begin
      prep_tag.status = hpc_pkg::STATUS_COMPUTED;
    end
    prep_tag.neg = dz[33] ^ sd.bz[CW-1];
  end

  logic              v3_q;
  hpc_pkg::div_tag_t tag3_q;
  logic [30:0]       a1_q, a2_q, dm_q, zm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= sv_q[ANG_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    tag3_q <= prep_tag;
    a1_q   <= a1;
    a2_q   <= a2;
    dm_q   <= dmag[30:0];
    zm_q   <= zmag[30:0];
  end

  // ---------------- divider ----------------
  logic              dv;
  hpc_pkg::div_tag_t dtag;
  logic [32:0]       dmag_q16;

  hpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(v3_q),
    .tag_i  (tag3_q),
    .a1_i   (a1_q),
    .dm_i   (dm_q),
    .a2_i   (a2_q),
    .zm_i   (zm_q),
    .valid_o(dv),
    .tag_o  (dtag),
    .mag_o  (dmag_q16)
  );

  // ---------------- sign, saturation, bounds ----------------
  logic signed [31:0] ratio;

  always_comb begin
    case (dtag.status)
      hpc_pkg::STATUS_COMPUTED: begin
        if (dtag.neg) begin
          ratio = (dmag_q16 > 33'h080000000) ? 32'sh80000000 : -$signed(dmag_q16[31:0]);
        end else begin
          ratio = (dmag_q16 > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : $signed(dmag_q16[31:0]);
        end
      end
      default: ratio = hpc_pkg::ONE_Q16;
    endcase
  end

  logic              done_q, compat_q;
  logic signed [31:0] ratio_q;
  hpc_pkg::status_e   status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= dv;
    end
  end

  always_ff @(posedge clk_i) begin
    ratio_q  <= ratio;
    status_q <= dtag.status;
    compat_q <= (ratio >= ratio_min_q) && (ratio <= ratio_max_q);
  end

  assign done_o         = done_q;
  assign compatible_o   = compat_q;
  assign ratio_value_o  = ratio_q;
  assign ratio_status_o = status_q;

endmodule

[src/hpc_angle.sv]
module hpc_angle #(
  parameter int COORD_WIDTH  = hpc_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                      clk_i,
  input  logic signed [COORD_WIDTH:0] px_i,
  input  logic signed [COORD_WIDTH:0] py_i,
  input  logic signed [COORD_WIDTH:0] qx_i,
  input  logic signed [COORD_WIDTH:0] qy_i,
  output logic [30:0]               angle_o
);

  // shift both magnitudes together until each is below 2^30, keep signs
  function automatic logic [61:0] fit_pair(input logic signed [32:0] x,
                                           input logic signed [32:0] y);
    logic [32:0] mx, my;
    logic signed [30:0] rx, ry;
    mx = x[32] ? (~x + 33'd1) : x;
    my = y[32] ? (~y + 33'd1) : y;
    for (int k = 0; k < 3; k++) begin
      if ((mx | my) >= 33'h040000000) begin
        mx = mx >> 1;
        my = my >> 1;
      end
    end
    rx = x[32] ? -$signed(mx[30:0]) : $signed(mx[30:0]);
    ry = y[32] ? -$signed(my[30:0]) : $signed(my[30:0]);
    return {rx, ry};
  endfunction

  logic signed [30:0] fpx_q, fpy_q, fqx_q, fqy_q;
  logic signed [61:0] m0_q, m1_q, m2_q, m3_q;
  logic [62:0]        c_q, d_q;

  logic signed [42:0] x_q [0:CORDIC_STEPS];
  logic signed [42:0] y_q [0:CORDIC_STEPS];
  logic signed [32:0] z_q [0:CORDIC_STEPS];
  logic               cz_q [0:CORDIC_STEPS];
  logic               dz_q [0:CORDIC_STEPS];
  logic [30:0]        angle_q;

  logic [61:0] fit_p, fit_q;
  logic signed [62:0] cr, dt;
  logic [62:0] cr_mag, dt_mag, cd, c_red, d_red;
  logic [4:0]  red_sh;

  assign fit_p = fit_pair(33'(px_i), 33'(py_i));
  assign fit_q = fit_pair(33'(qx_i), 33'(qy_i));

  // fit vectors
  always_ff @(posedge clk_i) begin
    fpx_q <= $signed(fit_p[61:31]);
    fpy_q <= $signed(fit_p[30:0]);
    fqx_q <= $signed(fit_q[61:31]);
    fqy_q <= $signed(fit_q[30:0]);
  end

  // products for cross and dot
  always_ff @(posedge clk_i) begin
    m0_q <= fpx_q * fqy_q;
    m1_q <= fpy_q * fqx_q;
    m2_q <= fpx_q * fqx_q;
    m3_q <= fpy_q * fqy_q;
  end

  always_comb begin
    cr     = 63'(m0_q) - 63'(m1_q);
    dt     = 63'(m2_q) + 63'(m3_q);
    cr_mag = cr[62] ? 63'(-cr) : 63'(cr);
    dt_mag = dt[62] ? 63'(-dt) : 63'(dt);
  end

  always_ff @(posedge clk_i) begin
    c_q <= cr_mag;
    d_q <= dt_mag;
  end

  // common shift that brings both below 2^40
  always_comb begin
    cd     = c_q | d_q;
    red_sh = 5'd0;
    for (int j = 0; j < 23; j++) begin
      if ((cd >> (40 + j)) != 63'd0) red_sh = 5'(j + 1);
    end
    c_red = c_q >> red_sh;
    d_red = d_q >> red_sh;
  end

  always_ff @(posedge clk_i) begin
    x_q[0]  <= $signed(43'(d_red));
    y_q[0]  <= $signed(43'(c_red));
    z_q[0]  <= 33'sd0;
    cz_q[0] <= (c_red == 63'd0);
    dz_q[0] <= (d_red == 63'd0);
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    localparam logic signed [32:0] ATAN = $signed({2'b00, hpc_pkg::atan_q30(i)});
    logic signed [42:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_ff @(posedge clk_i) begin
      cz_q[i+1] <= cz_q[i];
      dz_q[i+1] <= dz_q[i];
      if (y_q[i] > 43'sd0) begin
        x_q[i+1] <= x_q[i] + ys;
        y_q[i+1] <= y_q[i] - xs;
        z_q[i+1] <= z_q[i] + ATAN;
      end else if (y_q[i] < 43'sd0) begin
        x_q[i+1] <= x_q[i] - ys;
        y_q[i+1] <= y_q[i] + xs;
        z_q[i+1] <= z_q[i] - ATAN;
      end else begin
        // hold once the vector lies on the axis
        x_q[i+1] <= x_q[i];
        y_q[i+1] <= y_q[i];
        z_q[i+1] <= z_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cz_q[CORDIC_STEPS]) begin
      angle_q <= 31'd0;
    end else if (dz_q[CORDIC_STEPS]) begin
      angle_q <= hpc_pkg::HALF_PI_Q30;
    end else if (z_q[CORDIC_STEPS] < 33'sd0) begin
      angle_q <= 31'd0;
    end else if (z_q[CORDIC_STEPS] > $signed({2'b00, hpc_pkg::HALF_PI_Q30})) begin
      angle_q <= hpc_pkg::HALF_PI_Q30;
    end else begin
      angle_q <= z_q[CORDIC_STEPS][30:0];
    end
  end

  assign angle_o = angle_q;

endmodule

[src/hpc_div.sv]
module hpc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  hpc_pkg::div_tag_t   tag_i,
  input  logic [30:0]         a1_i,
  input  logic [30:0]         dm_i,
  input  logic [30:0]         a2_i,
  input  logic [30:0]         zm_i,
  output logic                valid_o,
  output hpc_pkg::div_tag_t   tag_o,
  output logic [32:0]         mag_o
);

  localparam int QB = 32;

  logic [61:0]       num_q, den0_q;
  logic              vld0_q;
  hpc_pkg::div_tag_t tag0_q;

  logic [77:0]       rem_q [0:QB];
  logic [61:0]       den_q [0:QB];
  logic [QB-1:0]     quo_q [0:QB];
  logic              ovf_q [0:QB];
  logic              vld_q [0:QB];
  hpc_pkg::div_tag_t tag_q [0:QB];

  logic [77:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= a1_i * dm_i;
    den0_q <= a2_i * zm_i;
    tag0_q <= tag_i;
  end

  // integer part above 2^15 (or a zero divisor) saturates
  assign lim = {den0_q, 15'd0} + 78'(den0_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {num_q, 16'd0};
    den_q[0] <= den0_q;
    quo_q[0] <= '0;
    ovf_q[0] <= (78'(num_q) >= lim);
    tag_q[0] <= tag0_q;
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int B = QB - 1 - k;
    logic [93:0] sh;
    logic        take;
    assign sh   = 94'(den_q[k]) << B;
    assign take = (94'(rem_q[k]) >= sh);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= take ? 78'(94'(rem_q[k]) - sh) : rem_q[k];
      quo_q[k+1] <= quo_q[k] | (take ? (QB'(1) << B) : QB'(0));
      den_q[k+1] <= den_q[k];
      ovf_q[k+1] <= ovf_q[k];
      tag_q[k+1] <= tag_q[k];
    end
  end

  assign valid_o = vld_q[QB];
  assign tag_o   = tag_q[QB];
  assign mag_o   = ovf_q[QB] ? {1'b1, 32'd0} : {1'b0, quo_q[QB]};

endmodule

[src/hpc_checker.sv]
module hpc_checker #(
  parameter int CORDIC_STEPS = hpc_pkg::CORDIC_STEPS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] ratio_value_o,
  input logic [1:0]  ratio_status_o
);

  localparam int LAT = hpc_pkg::pipe_latency(CORDIC_STEPS);

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("transaction result missing at fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start && !busy, LAT) |-> !done_o)
    else $error("result without a transaction");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (ratio_status_o == hpc_pkg::STATUS_COMPUTED ||
                ratio_status_o == hpc_pkg::STATUS_COLLINEAR ||
                ratio_status_o == hpc_pkg::STATUS_DEFAULT))
    else $error("bad ratio status");

  a_default_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && ratio_status_o != hpc_pkg::STATUS_COMPUTED)
      |-> ratio_value_o == hpc_pkg::ONE_Q16)
    else $error("default ratio is not one");

endmodule

bind helix_ip_hit_pair_check_core hpc_checker #(
  .CORDIC_STEPS(CORDIC_STEPS)
) u_hpc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .ratio_value_o (ratio_value_o),
  .ratio_status_o(ratio_status_o)
);

[tb/helix_ip_hit_pair_check_core_tb.sv]
module helix_ip_hit_pair_check_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW        = hpc_pkg::COORD_WIDTH_DEF;
  localparam int STEPS     = hpc_pkg::CORDIC_STEPS_DEF;
  localparam int LATENCY   = 43 + STEPS;
  localparam int WDOG_MAX  = 4000;
  localparam int N_RANDOM  = 310;

  // one pair of hits as seen on the input ports
  typedef struct {
    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
  } hit_pair_t;

  // one result as it should appear on the output ports
  typedef struct {
    logic               compat;
    logic signed [31:0] ratio;
    hpc_pkg::status_e   status;
  } pair_verdict_t;

  // Scoreboard: predicts the verdict for every accepted pair and checks each
  // result transaction against the oldest prediction still waiting.
  class pair_scoreboard;
    longint        lo_bound;
    longint        hi_bound;
    pair_verdict_t pending_verdicts[$];
    int            n_pairs, n_results, n_errors;
    int            n_status[3];
    longint        atan_q30[16];

    function new();
      lo_bound = 0;
      hi_bound = 131072;
      atan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                   131072, 65536, 32768};
    endfunction

    function void set_bound(hpc_pkg::reg_e idx, logic [31:0] val);
      if (idx == hpc_pkg::REG_RATIO_MIN) lo_bound = longint'(signed'(val));
      else hi_bound = longint'(signed'(val));
    endfunction

    function longint magn(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // smaller angle between two lines, Q2.30 radians, 0..pi/2
    function longint line_angle(longint px, longint py, longint qx, longint qy);
      longint mx, my, cr, dt, c, d, x, y, z, xs, ys;
      mx = magn(px); my = magn(py);
      while (mx >= (64'sd1 << 30) || my >= (64'sd1 << 30)) begin
        mx = mx >> 1; my = my >> 1;
      end
      px = (px < 0) ? -mx : mx; py = (py < 0) ? -my : my;
      mx = magn(qx); my = magn(qy);
      while (mx >= (64'sd1 << 30) || my >= (64'sd1 << 30)) begin
        mx = mx >> 1; my = my >> 1;
      end
      qx = (qx < 0) ? -mx : mx; qy = (qy < 0) ? -my : my;
      cr = px * qy - py * qx;
      dt = px * qx + py * qy;
      c = magn(cr); d = magn(dt);
      while (c >= (64'sd1 << 40) || d >= (64'sd1 << 40)) begin
        c = c >> 1; d = d >> 1;
      end
      if (c == 0) return 0;
      if (d == 0) return longint'(hpc_pkg::HALF_PI_Q30);
      x = d; y = c; z = 0;
      for (int i = 0; i < STEPS; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (y > 0) begin
          x += ys; y -= xs; z += atan_q30[i];
        end else if (y < 0) begin
          x -= ys; y += xs; z -= atan_q30[i];
        end else begin
          break;
        end
      end
      if (z < 0) z = 0;
      if (z > longint'(hpc_pkg::HALF_PI_Q30)) z = longint'(hpc_pkg::HALF_PI_Q30);
      return z;
    endfunction

    function pair_verdict_t predict_verdict(hit_pair_t p);
      pair_verdict_t v;
      longint ax, ay, az, bx, by, bz, a1, a2, dz, dm, zm, num, den, ip, r, f, m, ratio;
      bit neg;
      ax = p.ax; ay = p.ay; az = p.az; bx = p.bx; by = p.by; bz = p.bz;
      ratio = 65536;
      v.status = hpc_pkg::STATUS_COMPUTED;
      if (ax * by == ay * bx) begin
        v.status = hpc_pkg::STATUS_COLLINEAR;
      end else begin
        a1 = line_angle(-ax, -ay, bx - ax, by - ay);
        a2 = line_angle(ax, ay, bx, by);
        dz = az - bz;
        if (a2 == 0 || bz == 0) begin
          v.status = hpc_pkg::STATUS_DEFAULT;
        end else begin
          neg = (dz < 0) != (bz < 0);
          dm = magn(dz); zm = magn(bz);
          while (dm >= (64'sd1 << 31) || zm >= (64'sd1 << 31)) begin
            dm = dm >> 1; zm = zm >> 1;
          end
          num = a1 * dm;
          den = a2 * zm;
          if (den == 0) begin
            m = 64'sd1 << 32;
          end else begin
            ip = num / den; r = num % den; f = 0;
            if (ip > (64'sd1 << 15)) begin
              m = 64'sd1 << 32;
            end else begin
              for (int k = 0; k < 16; k++) begin
                r = r << 1; f = f << 1;
                if (r >= den) begin
                  r -= den; f |= 1;
                end
              end
              m = (ip << 16) | f;
            end
          end
          if (neg) begin
            if (m > (64'sd1 << 31)) m = 64'sd1 << 31;
            ratio = -m;
          end else begin
            if (m > 64'sh7FFFFFFF) m = 64'sh7FFFFFFF;
            ratio = m;
          end
        end
      end
      v.compat = (ratio >= lo_bound && ratio <= hi_bound);
      v.ratio  = ratio[31:0];
      return v;
    endfunction

    function void note_pair(hit_pair_t p);
      pending_verdicts.push_back(predict_verdict(p));
      n_pairs++;
    endfunction

    function void check_result(logic compat, logic signed [31:0] ratio, logic [1:0] status);
      pair_verdict_t v;
      n_results++;
      if (pending_verdicts.size() == 0) begin
        $error("result with no pair outstanding: ratio %0d status %0d", ratio, status);
        n_errors++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (status <= 2) n_status[status]++;
      if (compat !== v.compat) begin
        $error("compatible: expected %0b, got %0b", v.compat, compat);
        n_errors++;
      end
      if (ratio !== v.ratio) begin
        $error("ratio_value: expected %0d, got %0d", v.ratio, ratio);
        n_errors++;
      end
      if (status !== v.status) begin
        $error("ratio_status: expected %0d, got %0d", v.status, status);
        n_errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [CW-1:0] parent_x_i = '0, parent_y_i = '0, parent_z_i = '0;
  logic signed [CW-1:0] child_x_i = '0, child_y_i = '0, child_z_i = '0;
  logic                 done_o, compatible_o;
  logic signed [31:0]   ratio_value_o;
  logic [1:0]           ratio_status_o;
  logic                 psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;

  pair_scoreboard sb = new();
  int             idle_pct = 0;
  int             quiet_cycles = 0;

  helix_ip_hit_pair_check_core uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Note every accepted pair and check every result; both see the
  // pre-edge values, since the block and the drivers update by NBA.
  always @(posedge clk_i) begin
    hit_pair_t p;
    if (rst_ni) begin
      if (start && !busy) begin
        p.ax = parent_x_i; p.ay = parent_y_i; p.az = parent_z_i;
        p.bx = child_x_i;  p.by = child_y_i;  p.bz = child_z_i;
        sb.note_pair(p);
      end
      if (done_o) sb.check_result(compatible_o, ratio_value_o, ratio_status_o);
    end
  end

  // Watchdog: stop the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni && ((start && !busy) || done_o)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_MAX) begin
      $display("watchdog expired with %0d results outstanding", sb.pending_verdicts.size());
      $display("helix_ip_hit_pair_check_core_tb failed");
      $finish;
    end
  end

  // Present one pair and hold it until the block takes it; called at an edge.
  task automatic issue_pair(hit_pair_t p);
    start      <= 1'b1;
    parent_x_i <= p.ax; parent_y_i <= p.ay; parent_z_i <= p.az;
    child_x_i  <= p.bx; child_y_i  <= p.by; child_z_i  <= p.bz;
    do @(posedge clk_i); while (busy);
    // idle the sender for a random share of the cycles
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
  endtask

  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drain every outstanding transaction, then let the pipeline settle.
  task automatic drain();
    hold_off();
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_bound(hpc_pkg::reg_e idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_bound(idx, val);
    @(posedge clk_i);
  endtask

  function automatic hit_pair_t make_pair(int ax, int ay, int az, int bx, int by, int bz);
    hit_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.az = CW'(az);
    p.bx = CW'(bx); p.by = CW'(by); p.bz = CW'(bz);
    return p;
  endfunction

  function automatic logic signed [CW-1:0] any_coord();
    return CW'($urandom);
  endfunction

  function automatic int near_coord(int lim);
    return int'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  // Random pair with a bias towards the default paths and saturation.
  function automatic hit_pair_t random_pair();
    hit_pair_t p;
    int sel, k;
    sel = $urandom_range(0, 99);
    p.ax = any_coord(); p.ay = any_coord(); p.az = any_coord();
    p.bx = any_coord(); p.by = any_coord(); p.bz = any_coord();
    if (sel < 10) begin
      // child on the line through origin and parent
      p.ax = CW'(near_coord(4000)); p.ay = CW'(near_coord(4000));
      k = near_coord(2000);
      p.bx = CW'(p.ax * k); p.by = CW'(p.ay * k);
    end else if (sel < 15) begin
      p.bz = '0;
    end else if (sel < 20) begin
      // nearly collinear: tiny cross against a huge dot product
      k = near_coord(3);
      p.ax = CW'(8388607 - $urandom_range(0, 50)); p.ay = CW'(k);
      p.bx = CW'(p.ax - $urandom_range(1, 4));     p.by = CW'(k + near_coord(1));
    end else if (sel < 30) begin
      p.bz = CW'(near_coord(3));
    end else if (sel < 60) begin
      p.ax = CW'(near_coord(2000)); p.ay = CW'(near_coord(2000));
      p.az = CW'(near_coord(2000));
      p.bx = CW'(near_coord(2000)); p.by = CW'(near_coord(2000));
      p.bz = CW'(near_coord(2000));
    end
    return p;
  endfunction

  task automatic run_random(int n);
    for (int i = 0; i < n; i++) issue_pair(random_pair());
  endtask

  initial begin
    hit_pair_t directed[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed pairs under the reset bounds
    directed = '{
      make_pair(0, 0, 0, 0, 0, 0),                                     // both at origin
      make_pair(0, 0, 100, 300, 400, 50),                              // parent at origin
      make_pair(1200, -700, 30, 1200, -700, 90),                       // equal hits
      make_pair(150, 200, 10, 300, 400, 20),                           // child twice parent
      make_pair(1000, 0, 500, 0, 1000, 0),                             // child z zero
      make_pair(8388607, 1, 200, 8388606, 1, 100),                     // alpha2 vanishes
      make_pair(100, 0, 8388607, 0, 100, 1),                           // saturate high
      make_pair(100, 0, -8388608, 0, 100, 1),                          // saturate low
      make_pair(8388607, 8388607, 8388607, -8388608, 8388607, 8388607),
      make_pair(-8388608, -8388608, -8388608, 8388607, -8388608, -8388608),
      make_pair(8388607, -8388608, 8388607, -8388608, -8388608, -8388608),
      make_pair(-8388608, 8388607, -8388608, 8388607, 8388607, 8388607),
      make_pair(1000, 0, 200, 0, 1000, 100),                           // ratio about one half
      make_pair(1000, 0, 300, 0, 1000, 100),                           // ratio about one
      make_pair(1000, 0, -100, 0, 1000, 100),                          // negative ratio
      make_pair(1, 0, 3, 0, 1, 1),
      make_pair(-5000, 3000, 7000, 2000, -6000, -4000),
      make_pair(1000, 1, 5, -1000, 2, 7)                               // near half turn
    };
    foreach (directed[i]) issue_pair(directed[i]);
    drain();

    // wide open bounds, sender idles about a third of the time
    write_bound(hpc_pkg::REG_RATIO_MIN, 32'h8000_0000);
    write_bound(hpc_pkg::REG_RATIO_MAX, 32'h7FFF_FFFF);
    idle_pct = 33;
    run_random(N_RANDOM / 2);
    // hold off until every outstanding result has come back
    hold_off();
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
    run_random(N_RANDOM / 2);
    drain();

    // a single point window at exactly 1.0, sender idles more than half the time
    write_bound(hpc_pkg::REG_RATIO_MIN, 32'h0001_0000);
    write_bound(hpc_pkg::REG_RATIO_MAX, 32'h0001_0000);
    idle_pct = 54;
    run_random(N_RANDOM);
    drain();

    // window from -2.0 to 0.5, then an empty one (min above max), pairs back to back
    write_bound(hpc_pkg::REG_RATIO_MIN, 32'hFFFE_0000);
    write_bound(hpc_pkg::REG_RATIO_MAX, 32'h0000_8000);
    idle_pct = 0;
    run_random(N_RANDOM / 2);
    drain();
    write_bound(hpc_pkg::REG_RATIO_MIN, 32'h7FFF_FFFF);
    write_bound(hpc_pkg::REG_RATIO_MAX, 32'h8000_0000);
    run_random(N_RANDOM / 2);
    drain();

    $display("covered %0d pairs, %0d results: %0d computed, %0d collinear, %0d defaulted",
             sb.n_pairs, sb.n_results, sb.n_status[0], sb.n_status[1], sb.n_status[2]);
    $display("bounds swept through reset, full range, exact 1.0, negative and empty windows");
    if (sb.n_errors == 0 && sb.pending_verdicts.size() == 0) begin
      $display("helix_ip_hit_pair_check_core_tb passed");
    end else begin
      $display("helix_ip_hit_pair_check_core_tb failed");
    end
    $finish;
  end

endmodule

[files.f]
src/hpc_pkg.sv
src/hpc_angle.sv
src/hpc_div.sv
src/helix_ip_hit_pair_check_core.sv
src/hpc_checker.sv
tb/helix_ip_hit_pair_check_core_tb.sv
